[rtl/ibta_pkg.sv]
// ----------------------------------------------------------------------------
// ibta_pkg
// Shared types, codes and helpers of the blocked-address aging table.
// ----------------------------------------------------------------------------
package ibta_pkg;

    localparam int TableDepth = 16;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int WlCount    = 10;

    localparam logic [1:0] CMD_BLOCK   = 2'd0;
    localparam logic [1:0] CMD_UNBLOCK = 2'd1;
    localparam logic [1:0] CMD_RATE    = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WHITELIST = 3'd1;
    localparam logic [2:0] ST_BCAST     = 3'd2;
    localparam logic [2:0] ST_BAD_SEV   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NO_CHANGE = 3'd5;

    localparam logic [2:0] JOB_NONE     = 3'd0;
    localparam logic [2:0] JOB_BLOCK    = 3'd1;
    localparam logic [2:0] JOB_UNBLOCK  = 3'd2;
    localparam logic [2:0] JOB_RATE     = 3'd3;
    localparam logic [2:0] JOB_UNRATE   = 3'd4;

    localparam logic [1:0] REG_DEFAULT_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_ESC_THRESHOLD   = 2'd1;
    localparam logic [1:0] REG_CLEANUP_PERIOD  = 2'd2;

    localparam logic [31:0] WL_BASE [WlCount] = '{
        32'h7F000000, 32'hA9FE0000, 32'hE0000000, 32'h08080808, 32'h08080404,
        32'h01010101, 32'h01000001, 32'hD043DEDE, 32'hD043DCDC, 32'hFFFFFFFF
    };
    localparam logic [31:0] WL_MASK [WlCount] = '{
        32'hFF000000, 32'hFFFF0000, 32'hF0000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF
    };

    typedef struct packed {
        logic [31:0] addr;
        logic        blocked;
        logic [2:0]  level;
        logic [15:0] custom;
        logic        permanent;
        logic        repeat_hit;
        logic [7:0]  violations;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic            en;
        logic [IdxW-1:0] idx;
        logic            valid;
        t_entry          entry;
    } t_tbl_wr;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  job;
        logic [31:0] job_addr;
        logic [2:0]  job_sev;
        logic        bnow;
        logic        lnow;
        logic [4:0]  bt;
        logic [4:0]  lt;
    } t_res;

    function automatic logic [19:0] eff_timeout(input t_entry e, input logic [15:0] dflt);
        logic [19:0] t;
        t = (e.custom != 16'd0) ? {4'd0, e.custom} : {4'd0, dflt};
        if (e.permanent && e.repeat_hit) begin
            t = (t << 3) + (t << 1);
        end
        return t;
    endfunction

endpackage

[rtl/ibta_class.sv]
// ----------------------------------------------------------------------------
// ibta_class
// Address classifier: fixed whitelist and broadcast or multicast detection.
// ----------------------------------------------------------------------------
module ibta_class import ibta_pkg::*; (
    input  logic [31:0] i_addr,
    output logic        o_whitelisted,
    output logic        o_bcast
);

    always_comb begin
        o_whitelisted = 1'b0;
        for (int k = 0; k < WlCount; k++) begin
            if ((i_addr & WL_MASK[k]) == WL_BASE[k]) begin
                o_whitelisted = 1'b1;
            end
        end
    end

    assign o_bcast = (i_addr == 32'hFFFFFFFF)
                  || (i_addr >= 32'hE0000000 && i_addr <= 32'hEFFFFFFF)
                  || (i_addr[7:0] == 8'hFF);

endmodule

[rtl/ibta_table.sv]
// ----------------------------------------------------------------------------
// ibta_table
// Entry store with one read and one write port; valid bits cleared at reset.
// ----------------------------------------------------------------------------
module ibta_table import ibta_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [IdxW-1:0] i_rd_idx,
    output logic            o_rd_valid,
    output t_entry          o_rd_entry,
    input  t_tbl_wr         i_wr
);

    t_entry                r_mem [TableDepth];
    logic [TableDepth-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= i_wr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
    end

    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_entry = r_mem[i_rd_idx];

endmodule

[rtl/ip_block_table_aging.sv]
// ----------------------------------------------------------------------------
// ip_block_table_aging
// Blocked and rate-limited IPv4 address table with timed expiry sweep.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the last result of that request has been shown. Results appear on
// the o_* ports for one cycle each, marked by o_strobe, with o_last on the
// final one. The receiver cannot stall: every result must be taken on the
// cycle it is shown.
// Each request first scans all TableDepth entries, one per cycle, through a
// single table read port, then executes in the exec state. Unblock, rate
// limit, query and filtered block requests finish there with their single
// result. A block request that reaches the table and finds the cleanup
// period elapsed sweeps the table again, one entry per cycle, emitting one
// result per expired entry. A new request is taken only once busy is low.
// Registers are written over the APB port; the user must write them only
// while busy is low, which the block itself leaves unchecked.
// Reset clears all entry valid bits, the sweep time and the registers to
// their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ip_block_table_aging import ibta_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_addr,
    input  logic [15:0] i_duration,
    input  logic [2:0]  i_severity,
    input  logic [31:0] i_now_sec,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [2:0]  o_job,
    output logic [31:0] o_job_addr,
    output logic [2:0]  o_job_severity,
    output logic        o_blocked_now,
    output logic        o_limited_now,
    output logic [4:0]  o_blocked_total,
    output logic [4:0]  o_limited_total,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

    logic [2:0]      r_state, n_state;
    logic [IdxW-1:0] r_idx, n_idx;
    logic [1:0]      r_cmd;
    logic [31:0]     r_addr, r_now, r_last_sweep, n_last_sweep;
    logic [15:0]     r_dur;
    logic [2:0]      r_sev;
    logic [15:0]     r_dflt, r_period;
    logic [7:0]      r_thresh;
    logic            r_hit, n_hit, r_free, n_free;
    logic [IdxW-1:0] r_hit_idx, n_hit_idx, r_free_idx, n_free_idx;
    logic [4:0]      r_bt, n_bt, r_lt, n_lt;
    t_res            r_pend, n_pend, r_out, n_out;
    logic            r_out_vld, n_out_vld, r_out_last, n_out_last;

    logic            rd_valid;
    t_entry          rd_e;
    t_tbl_wr         wr;
    logic            wl, bc;
    logic [31:0]     el;
    logic [19:0]     tmo;
    logic [7:0]      viol_inc;
    logic            cfg_wr;

    ibta_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_idx),
        .o_rd_valid (rd_valid),
        .o_rd_entry (rd_e),
        .i_wr       (wr)
    );

    ibta_class u_class (
        .i_addr        (r_addr),
        .o_whitelisted (wl),
        .o_bcast       (bc)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt   <= 16'd60;
            r_thresh <= 8'd5;
            r_period <= 16'd10;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_DEFAULT_TIMEOUT: r_dflt   <= pwdata[15:0];
                REG_ESC_THRESHOLD:   r_thresh <= pwdata[7:0];
                REG_CLEANUP_PERIOD:  r_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEFAULT_TIMEOUT: prdata = {16'd0, r_dflt};
            REG_ESC_THRESHOLD:   prdata = {24'd0, r_thresh};
            REG_CLEANUP_PERIOD:  prdata = {16'd0, r_period};
            default:             prdata = 32'd0;
        endcase
    end

    assign el       = r_now - rd_e.stamp;
    assign tmo      = eff_timeout(rd_e, r_dflt);
    assign viol_inc = (rd_e.violations == 8'hFF) ? 8'hFF : rd_e.violations + 8'd1;

    always_comb begin
        t_res   res;
        t_entry ne;
        logic   sev_bad;
        logic   go_sweep;
        res          = '0;
        ne           = rd_e;
        sev_bad      = (r_sev == 3'd0) || (r_sev > 3'd4);
        go_sweep     = 1'b0;
        n_state      = r_state;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_free       = r_free;
        n_free_idx   = r_free_idx;
        n_bt         = r_bt;
        n_lt         = r_lt;
        n_pend       = r_pend;
        n_out        = r_out;
        n_out_vld    = 1'b0;
        n_out_last   = 1'b0;
        n_last_sweep = r_last_sweep;
        wr           = '0;
        wr.idx       = r_idx;
        wr.entry     = rd_e;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_bt    = '0;
                    n_lt    = '0;
                end
            end
            S_SCAN: begin
                if (rd_valid) begin
                    if (rd_e.addr == r_addr && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_idx;
                    end
                    if (rd_e.blocked) begin
                        if (r_bt != 5'd31) n_bt = r_bt + 5'd1;
                    end else if (rd_e.level != 3'd0) begin
                        if (r_lt != 5'd31) n_lt = r_lt + 5'd1;
                    end
                end else if (!r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_idx;
                end
                if (r_idx == LastIdx) begin
                    n_state = S_EXEC;
                    n_idx   = n_hit ? n_hit_idx : n_free_idx;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_BLOCK: begin
                        if (wl) begin
                            res.status = ST_WHITELIST;
                        end else if (bc) begin
                            res.status = ST_BCAST;
                        end else begin
                            go_sweep = (r_now - r_last_sweep) >= {16'd0, r_period};
                            if (r_hit && rd_e.blocked) begin
                                ne.stamp      = r_now;
                                ne.violations = viol_inc;
                                if (r_dur != 16'd0) ne.custom = r_dur;
                                if (viol_inc >= r_thresh) begin
                                    ne.permanent  = 1'b1;
                                    ne.repeat_hit = 1'b1;
                                end
                                wr.en    = 1'b1;
                                wr.valid = 1'b1;
                                wr.entry = ne;
                            end else if (r_hit || r_free) begin
                                ne.addr       = r_addr;
                                ne.blocked    = 1'b1;
                                ne.level      = 3'd0;
                                ne.custom     = r_dur;
                                ne.permanent  = 1'b0;
                                ne.repeat_hit = r_hit && (rd_e.violations >= 8'd3
                                                          || rd_e.repeat_hit);
                                ne.violations = 8'd1;
                                ne.stamp      = r_now;
                                wr.en         = 1'b1;
                                wr.valid      = 1'b1;
                                wr.entry      = ne;
                                res.job       = JOB_BLOCK;
                                res.job_addr  = r_addr;
                            end else begin
                                res.status = ST_FULL;
                            end
                        end
                    end
                    CMD_UNBLOCK: begin
                        if (r_hit && rd_e.blocked) begin
                            wr.en        = 1'b1;
                            wr.valid     = 1'b0;
                            res.job      = JOB_UNBLOCK;
                            res.job_addr = r_addr;
                        end else begin
                            res.status = ST_NO_CHANGE;
                        end
                    end
                    CMD_RATE: begin
                        if (sev_bad) begin
                            res.status = ST_BAD_SEV;
                        end else if (wl) begin
                            res.status = ST_WHITELIST;
                        end else if (bc) begin
                            res.status = ST_BCAST;
                        end else if (!r_hit) begin
                            if (r_free) begin
                                ne.addr       = r_addr;
                                ne.blocked    = 1'b0;
                                ne.level      = r_sev;
                                ne.custom     = 16'd0;
                                ne.permanent  = 1'b0;
                                ne.repeat_hit = 1'b0;
                                ne.violations = 8'd1;
                                ne.stamp      = r_now;
                                wr.en         = 1'b1;
                                wr.valid      = 1'b1;
                                wr.entry      = ne;
                                res.job       = JOB_RATE;
                                res.job_addr  = r_addr;
                                res.job_sev   = r_sev;
                            end else begin
                                res.status = ST_FULL;
                            end
                        end else if (r_sev > rd_e.level) begin
                            ne.level     = r_sev;
                            ne.stamp     = r_now;
                            wr.en        = 1'b1;
                            wr.valid     = 1'b1;
                            wr.entry     = ne;
                            res.job      = JOB_RATE;
                            res.job_addr = r_addr;
                            res.job_sev  = r_sev;
                        end else begin
                            res.status = ST_NO_CHANGE;
                        end
                    end
                    default: begin
                        res.bnow = r_hit && rd_e.blocked && (el <= {12'd0, tmo});
                        res.lnow = r_hit && (rd_e.level != 3'd0)
                                && (el <= {17'd0, r_dflt[15:1]});
                        res.bt   = r_bt;
                        res.lt   = r_lt;
                    end
                endcase
                if (go_sweep) begin
                    n_pend       = res;
                    n_last_sweep = r_now;
                    n_idx        = '0;
                    n_state      = S_SWEEP;
                end else begin
                    n_out      = res;
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (rd_valid) begin
                    if (rd_e.blocked && el >= {12'd0, tmo}) begin
                        res.job = JOB_UNBLOCK;
                    end else if (!rd_e.blocked && rd_e.level != 3'd0
                                 && el >= {13'd0, tmo[19:1]}) begin
                        res.job = JOB_UNRATE;
                    end
                    if (res.job != JOB_NONE) begin
                        res.job_addr = rd_e.addr;
                        wr.en        = 1'b1;
                        wr.valid     = 1'b0;
                        n_out        = r_pend;
                        n_out_vld    = 1'b1;
                        n_pend       = res;
                    end
                end
                if (r_idx == LastIdx) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FLUSH: begin
                n_out      = r_pend;
                n_out_vld  = 1'b1;
                n_out_last = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_vld    <= 1'b0;
            r_out_last   <= 1'b0;
            r_last_sweep <= 32'd0;
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_free       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_vld    <= n_out_vld;
            r_out_last   <= n_out_last;
            r_last_sweep <= n_last_sweep;
            r_idx        <= n_idx;
            r_hit        <= n_hit;
            r_free       <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_bt       <= n_bt;
        r_lt       <= n_lt;
        r_pend     <= n_pend;
        r_out      <= n_out;
        if (r_state == S_IDLE && start) begin
            r_cmd  <= i_cmd;
            r_addr <= i_addr;
            r_dur  <= i_duration;
            r_sev  <= i_severity;
            r_now  <= i_now_sec;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_out_vld;
    assign o_last          = r_out_last;
    assign o_status        = r_out.status;
    assign o_job           = r_out.job;
    assign o_job_addr      = r_out.job_addr;
    assign o_job_severity  = r_out.job_sev;
    assign o_blocked_now   = r_out.bnow;
    assign o_limited_now   = r_out.lnow;
    assign o_blocked_total = r_out.bt;
    assign o_limited_total = r_out.lt;

`ifndef SYNTHESIS
    a_done_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe && o_last)
        else $error("request finished without a last result");

    a_last_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("last result shown while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_no_job_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_job == JOB_NONE |-> o_job_addr == 32'd0)
        else $error("job address set without a job");
`endif

endmodule

[dv/ip_block_table_aging_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_block_table_aging_test
// Self-checking bench for the blocked-address aging table. A directed table
// of requests covers the whitelist, broadcast, bad severity, refresh and
// rebuild cases, then random requests over a small address pool run under
// several register settings. Every result is checked against a predictor
// of the table, its sweep and its totals.
// ----------------------------------------------------------------------------
module ip_block_table_aging_test;
    import ibta_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  job;
        logic [31:0] job_addr;
        logic [2:0]  job_sev;
        logic        bnow;
        logic        lnow;
        logic [4:0]  bt;
        logic [4:0]  lt;
        logic        last;
    } t_answer;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] addr;
        logic [15:0] dur;
        logic [2:0]  sev;
        logic [31:0] now;
        bit          typed;
        logic [2:0]  exp_status;
        logic [2:0]  exp_job;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [31:0] i_addr = '0;
    logic [15:0] i_duration = '0;
    logic [2:0]  i_severity = '0;
    logic [31:0] i_now_sec = '0;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [2:0]  o_job;
    logic [31:0] o_job_addr;
    logic [2:0]  o_job_severity;
    logic        o_blocked_now;
    logic        o_limited_now;
    logic [4:0]  o_blocked_total;
    logic [4:0]  o_limited_total;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ip_block_table_aging u_dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [15:0] dflt_timeout;
    logic [7:0]  esc_threshold;
    logic [15:0] sweep_period;
    bit          tv [TableDepth];
    logic [31:0] ta [TableDepth];
    bit          tb [TableDepth];
    logic [2:0]  tlvl [TableDepth];
    logic [15:0] tcust [TableDepth];
    bit          tperm [TableDepth];
    bit          trep [TableDepth];
    logic [7:0]  tviol [TableDepth];
    logic [31:0] tstamp [TableDepth];
    logic [31:0] last_sweep;

    t_answer     expected_answers [$];
    int          mismatches = 0;
    int          burst_left = 0;
    logic [31:0] clock_sec;
    logic [31:0] addr_pool [24];

    function automatic bit wl_match(logic [31:0] a);
        for (int k = 0; k < WlCount; k++) begin
            if ((a & WL_MASK[k]) == WL_BASE[k]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit is_bcast(logic [31:0] a);
        return (a == 32'hFFFFFFFF) || (a >= 32'hE0000000 && a <= 32'hEFFFFFFF) ||
               (a[7:0] == 8'hFF);
    endfunction

    function automatic logic [31:0] entry_timeout(int k);
        logic [31:0] t;
        t = (tcust[k] != 0) ? {16'd0, tcust[k]} : {16'd0, dflt_timeout};
        if (tperm[k] && trep[k]) t = t * 10;
        return t;
    endfunction

    function automatic t_answer mk(logic [2:0] st, logic [2:0] jb, logic [31:0] a,
                                   logic [2:0] sv);
        t_answer r;
        r = '0;
        r.status = st;
        r.job = jb;
        r.job_addr = a;
        r.job_sev = sv;
        return r;
    endfunction

    function automatic void append_answer(ref t_answer q [$], input t_answer a);
        q = {q, a};
    endfunction

    function automatic void clear_table();
        for (int k = 0; k < TableDepth; k++) begin
            tv[k] = 0; ta[k] = 0; tb[k] = 0; tlvl[k] = 0; tcust[k] = 0;
            tperm[k] = 0; trep[k] = 0; tviol[k] = 0; tstamp[k] = 0;
        end
        last_sweep = 0;
        dflt_timeout = 16'd60;
        esc_threshold = 8'd5;
        sweep_period = 16'd10;
    endfunction

    function automatic void fill_entry(int k, logic [31:0] a, bit blk, logic [2:0] lvl,
                                       logic [15:0] cust, bit rep, logic [31:0] now);
        tv[k] = 1; ta[k] = a; tb[k] = blk; tlvl[k] = lvl; tcust[k] = cust;
        tperm[k] = 0; trep[k] = rep; tviol[k] = 8'd1; tstamp[k] = now;
    endfunction

    // compute answers for one request and update the table copy
    function automatic void predict_request(t_row rq, ref t_answer res [$]);
        int hit = -1;
        int slot;
        logic [31:0] el, t;
        logic [4:0] bcnt, lcnt;
        t_answer r;
        bit rep;
        for (int k = 0; k < TableDepth; k++) begin
            if (hit < 0 && tv[k] && ta[k] == rq.addr) hit = k;
        end
        res.delete();
        case (rq.cmd)
            CMD_BLOCK: begin
                if (wl_match(rq.addr)) begin
                    append_answer(res, mk(ST_WHITELIST, JOB_NONE, 0, 0));
                end else if (is_bcast(rq.addr)) begin
                    append_answer(res, mk(ST_BCAST, JOB_NONE, 0, 0));
                end else begin
                    if (hit >= 0 && tb[hit]) begin
                        tstamp[hit] = rq.now;
                        if (tviol[hit] < 8'd255) tviol[hit]++;
                        if (rq.dur != 0) tcust[hit] = rq.dur;
                        if (tviol[hit] >= esc_threshold) begin
                            tperm[hit] = 1; trep[hit] = 1;
                        end
                        append_answer(res, mk(ST_OK, JOB_NONE, 0, 0));
                    end else begin
                        rep = 0;
                        slot = hit;
                        if (slot >= 0) begin
                            rep = (tviol[slot] >= 8'd3) || trep[slot];
                        end else begin
                            for (int k = TableDepth - 1; k >= 0; k--) if (!tv[k]) slot = k;
                        end
                        if (slot < 0) begin
                            append_answer(res, mk(ST_FULL, JOB_NONE, 0, 0));
                        end else begin
                            fill_entry(slot, rq.addr, 1, 0, rq.dur, rep, rq.now);
                            append_answer(res, mk(ST_OK, JOB_BLOCK, rq.addr, 0));
                        end
                    end
                    if (rq.now - last_sweep >= {16'd0, sweep_period}) begin
                        last_sweep = rq.now;
                        for (int k = 0; k < TableDepth; k++) begin
                            if (!tv[k]) continue;
                            el = rq.now - tstamp[k];
                            t = entry_timeout(k);
                            if (el >= t && tb[k]) begin
                                append_answer(res, mk(ST_OK, JOB_UNBLOCK, ta[k], 0));
                                tv[k] = 0;
                            end else if (el >= t / 2 && tlvl[k] > 0 && !tb[k]) begin
                                append_answer(res, mk(ST_OK, JOB_UNRATE, ta[k], 0));
                                tv[k] = 0;
                            end
                        end
                    end
                end
            end
            CMD_UNBLOCK: begin
                if (hit >= 0 && tb[hit]) begin
                    tv[hit] = 0;
                    append_answer(res, mk(ST_OK, JOB_UNBLOCK, rq.addr, 0));
                end else begin
                    append_answer(res, mk(ST_NO_CHANGE, JOB_NONE, 0, 0));
                end
            end
            CMD_RATE: begin
                if (rq.sev < 1 || rq.sev > 4) begin
                    append_answer(res, mk(ST_BAD_SEV, JOB_NONE, 0, 0));
                end else if (wl_match(rq.addr)) begin
                    append_answer(res, mk(ST_WHITELIST, JOB_NONE, 0, 0));
                end else if (is_bcast(rq.addr)) begin
                    append_answer(res, mk(ST_BCAST, JOB_NONE, 0, 0));
                end else if (hit < 0) begin
                    slot = -1;
                    for (int k = TableDepth - 1; k >= 0; k--) if (!tv[k]) slot = k;
                    if (slot < 0) begin
                        append_answer(res, mk(ST_FULL, JOB_NONE, 0, 0));
                    end else begin
                        fill_entry(slot, rq.addr, 0, rq.sev, 0, 0, rq.now);
                        append_answer(res, mk(ST_OK, JOB_RATE, rq.addr, rq.sev));
                    end
                end else if (rq.sev > tlvl[hit]) begin
                    tlvl[hit] = rq.sev;
                    tstamp[hit] = rq.now;
                    append_answer(res, mk(ST_OK, JOB_RATE, rq.addr, rq.sev));
                end else begin
                    append_answer(res, mk(ST_NO_CHANGE, JOB_NONE, 0, 0));
                end
            end
            default: begin
                r = mk(ST_OK, JOB_NONE, 0, 0);
                if (hit >= 0) begin
                    el = rq.now - tstamp[hit];
                    r.bnow = tb[hit] && (el <= entry_timeout(hit));
                    r.lnow = (tlvl[hit] > 0) && (el <= {16'd0, dflt_timeout} / 2);
                end
                bcnt = 0;
                lcnt = 0;
                for (int k = 0; k < TableDepth; k++) begin
                    if (!tv[k]) continue;
                    if (tb[k]) begin
                        if (bcnt < 31) bcnt++;
                    end else if (tlvl[k] > 0) begin
                        if (lcnt < 31) lcnt++;
                    end
                end
                r.bt = bcnt;
                r.lt = lcnt;
                append_answer(res, r);
            end
        endcase
        res[res.size() - 1].last = 1'b1;
    endfunction

    task automatic send_request(t_row rq);
        t_answer res [$];
        start <= 1'b1;
        i_cmd <= rq.cmd;
        i_addr <= rq.addr;
        i_duration <= rq.dur;
        i_severity <= rq.sev;
        i_now_sec <= rq.now;
        do @(posedge i_clk); while (busy);
        predict_request(rq, res);
        if (rq.typed) begin
            res[0].status = rq.exp_status;
            res[0].job = rq.exp_job;
        end
        foreach (res[k]) append_answer(expected_answers, res[k]);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 6);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (2 * TableDepth + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DEFAULT_TIMEOUT: dflt_timeout = val[15:0];
            REG_ESC_THRESHOLD:   esc_threshold = val[7:0];
            default:             sweep_period = val[15:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [15:0] dt, logic [7:0] th, logic [15:0] cp);
        drain();
        write_reg(REG_DEFAULT_TIMEOUT, {16'd0, dt});
        write_reg(REG_ESC_THRESHOLD, {24'd0, th});
        write_reg(REG_CLEANUP_PERIOD, {16'd0, cp});
    endtask

    function automatic t_row rand_row();
        t_row rq;
        int pick;
        rq.typed = 0;
        rq.exp_status = ST_OK;
        rq.exp_job = JOB_NONE;
        pick = $urandom_range(0, 99);
        rq.cmd = (pick < 40) ? CMD_BLOCK : (pick < 65) ? CMD_RATE :
                 (pick < 80) ? CMD_UNBLOCK : CMD_QUERY;
        pick = $urandom_range(0, 99);
        if (pick < 80) rq.addr = addr_pool[$urandom_range(0, 23)];
        else if (pick < 90) rq.addr = $urandom;
        else if (pick < 95) rq.addr = WL_BASE[$urandom_range(0, WlCount - 1)] |
                                      ($urandom & ~WL_MASK[0]);
        else rq.addr = {8'($urandom_range(0, 255)), 16'h1234, 8'hFF};
        pick = $urandom_range(0, 9);
        rq.dur = (pick < 6) ? 16'd0 : (pick < 9) ? 16'($urandom_range(1, 80)) : 16'($urandom);
        rq.sev = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 40) == 0) clock_sec = clock_sec + $urandom;
        else clock_sec = clock_sec + $urandom_range(0, 25);
        rq.now = clock_sec;
        return rq;
    endfunction

    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n && o_strobe) begin
            got = {o_status, o_job, o_job_addr, o_job_severity, o_blocked_now,
                   o_limited_now, o_blocked_total, o_limited_total, o_last};
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_answers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        #(4_000_000);
        $display("ip_block_table_aging regression: fail");
        $finish;
    end

    initial begin
        t_row dir [$];
        t_row rq;
        for (int k = 0; k < 24; k++) addr_pool[k] = {8'h0A, 8'(k), 8'h00, 8'(k + 1)};
        clear_table();
        dir = '{
            '{CMD_QUERY,   32'h0A000001, 0,      0, 100, 1, ST_OK,        JOB_NONE},
            '{CMD_BLOCK,   32'h7F000001, 0,      0, 100, 1, ST_WHITELIST, JOB_NONE},
            '{CMD_BLOCK,   32'hE0000005, 0,      0, 100, 1, ST_WHITELIST, JOB_NONE},
            '{CMD_BLOCK,   32'hFFFFFFFF, 0,      0, 100, 1, ST_WHITELIST, JOB_NONE},
            '{CMD_BLOCK,   32'hA9FE0102, 0,      0, 100, 1, ST_WHITELIST, JOB_NONE},
            '{CMD_BLOCK,   32'h0A0102FF, 0,      0, 100, 1, ST_BCAST,     JOB_NONE},
            '{CMD_RATE,    32'h0A000002, 0,      0, 100, 1, ST_BAD_SEV,   JOB_NONE},
            '{CMD_RATE,    32'h0A000002, 0,      7, 100, 1, ST_BAD_SEV,   JOB_NONE},
            '{CMD_RATE,    32'h08080808, 0,      2, 100, 1, ST_WHITELIST, JOB_NONE},
            '{CMD_RATE,    32'h0A0000FF, 0,      1, 100, 1, ST_BCAST,     JOB_NONE},
            '{CMD_UNBLOCK, 32'h0A090909, 0,      0, 100, 1, ST_NO_CHANGE, JOB_NONE},
            '{CMD_BLOCK,   32'h0A000001, 0,      0, 100, 0, ST_OK,        JOB_NONE},
            '{CMD_BLOCK,   32'h0A000001, 5,      0, 101, 0, ST_OK,        JOB_NONE},
            '{CMD_RATE,    32'h0A000002, 0,      4, 102, 0, ST_OK,        JOB_NONE},
            '{CMD_RATE,    32'h0A000002, 0,      3, 103, 1, ST_NO_CHANGE, JOB_NONE},
            '{CMD_BLOCK,   32'h0A000002, 0,      0, 104, 0, ST_OK,        JOB_NONE},
            '{CMD_QUERY,   32'h0A000001, 0,      0, 105, 0, ST_OK,        JOB_NONE},
            '{CMD_UNBLOCK, 32'h0A000001, 0,      0, 106, 0, ST_OK,        JOB_NONE},
            '{CMD_BLOCK,   32'h00000000, 65535,  0, 107, 0, ST_OK,        JOB_NONE},
            '{CMD_BLOCK,   32'hFFFFFFFE, 65535,  0, 108, 0, ST_OK,        JOB_NONE},
            '{CMD_RATE,    32'h0A000003, 0,      1, 109, 0, ST_OK,        JOB_NONE},
            '{CMD_BLOCK,   32'h0A000004, 0,      0, 400, 0, ST_OK,        JOB_NONE},
            '{CMD_QUERY,   32'hFFFFFFFE, 0,      0, 32'hFFFFFFFF, 0, ST_OK, JOB_NONE}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir[k]) send_request(dir[k]);
        clock_sec = 500;
        repeat (45) send_request(rand_row());
        set_regs(16'd1, 8'd1, 16'd0);
        repeat (35) send_request(rand_row());
        set_regs(16'd65535, 8'd255, 16'd65535);
        clock_sec = 32'hFFFFFF00;
        repeat (35) send_request(rand_row());
        set_regs(16'd30, 8'd3, 16'd5);
        repeat (35) send_request(rand_row());
        set_regs(16'd60, 8'd5, 16'd10);
        clock_sec = 32'h7FFFFFF0;
        repeat (35) send_request(rand_row());
        drain();
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("ip_block_table_aging regression: pass");
        end else begin
            $display("ip_block_table_aging regression: fail");
        end
        $finish;
    end

endmodule
